FILE: hdl/id_number_checksum_validator_core_macros.svh
// Assertion macros used by the validator core.
`ifndef ID_NUMBER_CHECKSUM_VALIDATOR_CORE_MACROS_SVH
`define ID_NUMBER_CHECKSUM_VALIDATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define IDCV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define IDCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define IDCV_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define IDCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/idcv_pkg.sv
`timescale 1ns / 1ps

package idcv_pkg;

	localparam int unsigned ID_LENGTH = 18;
	localparam int unsigned WEIGHTED_DIGITS = 17;
	localparam int unsigned PROVINCE_MAX = 82;
	localparam int unsigned POSITION_CAP = 19;
	localparam logic [13:0] YEAR_RESET = 14'd2023;
	localparam logic signed [15:0] AGE_MAX = 16'sd9999;

	typedef enum logic [2:0] {
		ST_VALID    = 3'd0,
		ST_LENGTH   = 3'd1,
		ST_NONDIGIT = 3'd2,
		ST_MISMATCH = 3'd3,
		ST_PROVINCE = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       is_last;
	} item_t;

	typedef struct packed {
		logic        is_male;
		logic [14:0] age_years;
		logic [13:0] birth_year;
		logic [13:0] region_code;
		logic [6:0]  province_id;
		status_t     status;
	} result_t;

	function automatic logic [3:0] digit_weight(input logic [4:0] pos);
		logic [3:0] w;
		unique case (pos)
			5'd0, 5'd10: w = 4'd7;
			5'd1, 5'd11: w = 4'd9;
			5'd2, 5'd12: w = 4'd10;
			5'd3, 5'd13: w = 4'd5;
			5'd4, 5'd14: w = 4'd8;
			5'd5, 5'd15: w = 4'd4;
			5'd6, 5'd16: w = 4'd2;
			5'd7:        w = 4'd1;
			5'd8:        w = 4'd6;
			5'd9:        w = 4'd3;
			default:     w = 4'd0;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] check_char(input logic [3:0] res);
		logic [7:0] c;
		unique case (res)
			4'd0:    c = "1";
			4'd1:    c = "0";
			4'd2:    c = "X";
			4'd3:    c = "9";
			4'd4:    c = "8";
			4'd5:    c = "7";
			4'd6:    c = "6";
			4'd7:    c = "5";
			4'd8:    c = "4";
			4'd9:    c = "3";
			4'd10:   c = "2";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Remainder by eleven for values up to 100, via a scaled reciprocal.
	function automatic logic [3:0] mod11(input logic [6:0] x);
		logic [14:0] p;
		logic [3:0]  q;
		logic [6:0]  r;
		p = {8'd0, x} * 15'd187;
		q = p[14:11];
		r = x - {3'd0, q} * 7'd11;
		return r[3:0];
	endfunction

endpackage

FILE: hdl/idcv_accum.sv
`timescale 1ns / 1ps

module idcv_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  idcv_pkg::item_t   item,
	input  logic [13:0]       reference_year,
	output idcv_pkg::result_t result
);
	import idcv_pkg::*;

	logic [4:0]  pos_q;
	logic [3:0]  residue_q;
	logic        non_digit_q;
	logic        matched_q;
	logic [6:0]  province_q;
	logic [13:0] region_q;
	logic [13:0] year_q;
	logic        odd_q;

	logic [3:0]  residue_d;
	logic        non_digit_d;
	logic        matched_d;
	logic [6:0]  province_d;
	logic [13:0] region_d;
	logic [13:0] year_d;
	logic        odd_d;
	logic [4:0]  pos_d;

	logic        is_digit;
	logic [3:0]  digit;
	logic [7:0]  product;
	logic [10:0] province_mac;
	logic [17:0] region_mac;
	logic [17:0] year_mac;
	logic signed [15:0] age_raw;
	logic signed [15:0] age_sat;
	status_t     status;

	assign is_digit = (item.char_in >= 8'h30) && (item.char_in <= 8'h39);
	assign digit = item.char_in[3:0];
	assign product = {4'd0, digit} * {4'd0, digit_weight(pos_q)};
	assign province_mac = {4'd0, province_q} * 11'd10 + {7'd0, digit};
	assign region_mac = {4'd0, region_q} * 18'd10 + {14'd0, digit};
	assign year_mac = {4'd0, year_q} * 18'd10 + {14'd0, digit};

	always_comb begin
		residue_d = residue_q;
		non_digit_d = non_digit_q;
		matched_d = matched_q;
		province_d = province_q;
		region_d = region_q;
		year_d = year_q;
		odd_d = odd_q;
		if (pos_q < 5'(WEIGHTED_DIGITS)) begin
			if (!is_digit) begin
				non_digit_d = 1'b1;
			end else begin
				residue_d = mod11(7'({3'd0, residue_q} + {1'b0, product[6:0]}));
				if (pos_q < 5'd2) begin
					province_d = province_mac[6:0];
				end else if (pos_q < 5'd6) begin
					region_d = region_mac[13:0];
				end else if (pos_q < 5'd10) begin
					year_d = year_mac[13:0];
				end else if (pos_q == 5'd16) begin
					odd_d = digit[0];
				end
			end
		end else if (pos_q == 5'(WEIGHTED_DIGITS)) begin
			matched_d = (item.char_in == check_char(residue_q));
		end
		pos_d = (pos_q < 5'(POSITION_CAP)) ? pos_q + 5'd1 : pos_q;
	end

	always_comb begin
		if (pos_q != 5'(ID_LENGTH - 1)) begin
			status = ST_LENGTH;
		end else if (non_digit_d) begin
			status = ST_NONDIGIT;
		end else if (!matched_d) begin
			status = ST_MISMATCH;
		end else if ((province_d == 7'd0) || (province_d > 7'(PROVINCE_MAX))) begin
			status = ST_PROVINCE;
		end else begin
			status = ST_VALID;
		end
	end

	assign age_raw = $signed({2'b00, reference_year}) - $signed({2'b00, year_d}) - 16'sd1;
	assign age_sat = (age_raw > AGE_MAX) ? AGE_MAX : age_raw;

	always_comb begin
		result = '0;
		result.status = status;
		if (status == ST_VALID || status == ST_PROVINCE) begin
			result.province_id = province_d;
		end
		if (status == ST_VALID) begin
			result.region_code = region_d;
			result.birth_year = year_d;
			result.age_years = age_sat[14:0];
			result.is_male = odd_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			residue_q <= '0;
			non_digit_q <= 1'b0;
			matched_q <= 1'b0;
			province_q <= '0;
			region_q <= '0;
			year_q <= '0;
			odd_q <= 1'b0;
		end else if (advance) begin
			if (item.is_last) begin
				pos_q <= '0;
				residue_q <= '0;
				non_digit_q <= 1'b0;
				matched_q <= 1'b0;
				province_q <= '0;
				region_q <= '0;
				year_q <= '0;
				odd_q <= 1'b0;
			end else begin
				pos_q <= pos_d;
				residue_q <= residue_d;
				non_digit_q <= non_digit_d;
				matched_q <= matched_d;
				province_q <= province_d;
				region_q <= region_d;
				year_q <= year_d;
				odd_q <= odd_d;
			end
		end
	end

endmodule

FILE: hdl/id_number_checksum_validator_core.sv
`timescale 1ns / 1ps
// Output: the last item of a string passes the input register, then its result and m_tvalid are registered together.
// Throughput: one item per cycle; the input register and the result register decouple
// the sides, so only a held result with a further last item behind it stalls input.
// Reset: arst_n clears all string state and valid flags asynchronously; reference_year
// returns to 2023.

`include "id_number_checksum_validator_core_macros.svh"

module id_number_checksum_validator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_in[7:0]
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // status[2:0], province_id[9:3], region_code[23:10],
	                               // birth_year[37:24], age_years[52:38], is_male[53], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [13:0] cfg_data   // reference_year
);
	import idcv_pkg::*;

	logic        s1_valid_q;
	item_t       item_s1;
	logic        s1_adv;
	logic [13:0] ref_year_q;
	result_t     result;
	result_t     result_q;
	logic        m_valid_q;

	assign cfg_ready = 1'b1;
	assign s1_adv = s1_valid_q && (!item_s1.is_last || !m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_year_q <= YEAR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ref_year_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.char_in <= s_tdata;
			item_s1.is_last <= s_tlast;
		end
	end

	idcv_accum u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (s1_adv),
		.item           (item_s1),
		.reference_year (ref_year_q),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_adv && item_s1.is_last) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && item_s1.is_last) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {2'b00, result_q};

	`IDCV_ASSERT_NEXT(a_last_gives_result, clk, arst_n, s1_adv && item_s1.is_last, m_tvalid)
	`IDCV_ASSERT_NEXT(a_held_result, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))
	`IDCV_ASSERT_SAME(a_failed_fields_zero, clk, arst_n,
		m_tvalid && (result_q.status != ST_VALID),
		(result_q.region_code == 14'd0) && (result_q.age_years == 15'd0) && !result_q.is_male)
	`IDCV_ASSERT_SAME(a_no_stall_mid_string, clk, arst_n,
		s1_valid_q && !item_s1.is_last, s_tready)

endmodule

FILE: tb/idcv_result_checker.sv
`timescale 1ns / 1ps

module idcv_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_in[7:0]
	input  logic        s_tlast,   // is_last
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,   // status, province, region, birth year, age, is_male, zero
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [13:0] cfg_data,  // reference_year
	output int          fails,
	output int          pending,
	output int          results_seen,
	output int          valid_seen
);
	import idcv_pkg::*;

	typedef struct {
		status_t     status;
		logic [6:0]  province;
		logic [13:0] region;
		logic [13:0] year;
		logic [14:0] age;
		logic        male;
	} id_fields_t;

	id_fields_t  expected_q[$];
	logic [13:0] ref_year;
	logic [4:0]  char_pos;
	logic [9:0]  digit_sum;
	logic        bad_char;
	logic        check_ok;
	logic [6:0]  province_acc;
	logic [13:0] region_acc;
	logic [13:0] year_acc;
	logic        odd_digit;

	function automatic logic [3:0] weight_at(input logic [4:0] p);
		case (p)
			5'd0, 5'd10: return 4'd7;
			5'd1, 5'd11: return 4'd9;
			5'd2, 5'd12: return 4'd10;
			5'd3, 5'd13: return 4'd5;
			5'd4, 5'd14: return 4'd8;
			5'd5, 5'd15: return 4'd4;
			5'd6, 5'd16: return 4'd2;
			5'd7: return 4'd1;
			5'd8: return 4'd6;
			5'd9: return 4'd3;
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic [7:0] check_symbol(input logic [9:0] sum);
		case (sum % 11)
			10'd0: return "1";
			10'd1: return "0";
			10'd2: return "X";
			10'd3: return "9";
			10'd4: return "8";
			10'd5: return "7";
			10'd6: return "6";
			10'd7: return "5";
			10'd8: return "4";
			10'd9: return "3";
			default: return "2";
		endcase
	endfunction

	task automatic clear_string();
		char_pos = '0;
		digit_sum = '0;
		bad_char = 1'b0;
		check_ok = 1'b0;
		province_acc = '0;
		region_acc = '0;
		year_acc = '0;
		odd_digit = 1'b0;
	endtask

	task automatic report(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		fails++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
				results_seen, name, got, want));
	endtask

	task automatic take_char(input logic [7:0] ch, input logic is_end);
		logic [4:0] at;
		logic [3:0] d;
		int         age_v;
		id_fields_t f;
		at = char_pos;
		if (at < 5'd17) begin
			if (ch < "0" || ch > "9") begin
				bad_char = 1'b1;
			end else begin
				d = 4'(ch - "0");
				digit_sum = 10'(digit_sum + d * weight_at(at));
				if (at < 5'd2)
					province_acc = 7'(province_acc * 10 + d);
				else if (at < 5'd6)
					region_acc = 14'(region_acc * 10 + d);
				else if (at < 5'd10)
					year_acc = 14'(year_acc * 10 + d);
				else if (at == 5'd16)
					odd_digit = d[0];
			end
		end else if (at == 5'd17) begin
			check_ok = (ch == check_symbol(digit_sum));
		end
		if (char_pos < 5'd19)
			char_pos++;
		if (is_end) begin
			f.province = '0;
			f.region = '0;
			f.year = '0;
			f.age = '0;
			f.male = 1'b0;
			if (at != 5'd17)
				f.status = ST_LENGTH;
			else if (bad_char)
				f.status = ST_NONDIGIT;
			else if (!check_ok)
				f.status = ST_MISMATCH;
			else if (province_acc < 7'd1 || province_acc > 7'd82)
				f.status = ST_PROVINCE;
			else
				f.status = ST_VALID;
			if (f.status == ST_PROVINCE) begin
				f.province = province_acc;
			end else if (f.status == ST_VALID) begin
				age_v = int'(ref_year) - int'(year_acc) - 1;
				if (age_v > 9999)
					age_v = 9999;
				if (age_v < -10000)
					age_v = -10000;
				f.province = province_acc;
				f.region = region_acc;
				f.year = year_acc;
				f.age = 15'(age_v);
				f.male = odd_digit;
			end
			expected_q.push_back(f);
			clear_string();
		end
	endtask

	task automatic compare_result(input logic [55:0] word);
		id_fields_t e;
		if (expected_q.size() == 0) begin
			report($sformatf("result %0d arrived with none outstanding", results_seen));
		end else begin
			e = expected_q.pop_front();
			check_field("status", word[2:0], e.status);
			check_field("province_id", word[9:3], e.province);
			check_field("region_code", word[23:10], e.region);
			check_field("birth_year", word[37:24], e.year);
			check_field("age_years", word[52:38], e.age);
			check_field("is_male", word[53], e.male);
			check_field("padding", word[55:54], 0);
			if (e.status == ST_VALID)
				valid_seen++;
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_year = YEAR_RESET;
			clear_string();
			expected_q.delete();
			fails = 0;
			results_seen = 0;
			valid_seen = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				ref_year = cfg_data;
			if (s_tvalid && s_tready)
				take_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				compare_result(m_tdata);
			pending <= expected_q.size();
		end
	end

endmodule

FILE: tb/id_number_checksum_validator_core_tb.sv
`timescale 1ns / 1ps

module id_number_checksum_validator_core_tb;
	import idcv_pkg::*;

	typedef logic [7:0] text_t[$];

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 95;
	localparam int SETTLE_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [13:0] cfg_data = 14'd0;
	logic        calm = 1'b0;

	int fails;
	int pending;
	int results_seen;
	int valid_seen;
	int cycles = 0;
	int chars_sent = 0;
	int strings_sent = 0;
	int years_tried = 1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	id_number_checksum_validator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	idcv_result_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.fails        (fails),
		.pending      (pending),
		.results_seen (results_seen),
		.valid_seen   (valid_seen)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycles, pending);
			$display("** id_number_checksum_validator_core: FAILED **");
			$finish;
		end
	end

	always @(negedge clk)
		m_tready = calm || ($urandom_range(99) >= 33);

	function automatic logic [7:0] digit_char(input int v);
		return 8'("0" + v);
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c >= "0" && c <= "9");
		return c;
	endfunction

	// Weights run as successive powers of two modulo eleven, from the seventeenth digit back.
	function automatic logic [7:0] check_symbol(input text_t s);
		int sum;
		int w;
		int r;
		sum = 0;
		w = 2;
		for (int i = 16; i >= 0; i--) begin
			sum += (s[i] - "0") * w;
			w = (w * 2) % 11;
		end
		r = (12 - sum % 11) % 11;
		return (r == 10) ? "X" : digit_char(r);
	endfunction

	function automatic text_t well_formed(input int prov, input int year_v);
		text_t s;
		s = {};
		s.push_back(digit_char(prov / 10));
		s.push_back(digit_char(prov % 10));
		repeat (4) s.push_back(digit_char($urandom_range(9)));
		s.push_back(digit_char(year_v / 1000));
		s.push_back(digit_char(year_v / 100 % 10));
		s.push_back(digit_char(year_v / 10 % 10));
		s.push_back(digit_char(year_v % 10));
		repeat (7) s.push_back(digit_char($urandom_range(9)));
		s.push_back(check_symbol(s));
		return s;
	endfunction

	// Mostly well-formed numbers; the rest carry a bad check character, a stray
	// non-digit, a wrong length, or are plain noise.
	function automatic text_t random_string();
		text_t s;
		int    kind;
		int    prov;
		int    n;
		kind = $urandom_range(99);
		if ($urandom_range(99) < 85)
			prov = $urandom_range(PROVINCE_MAX, 1);
		else if ($urandom_range(1) == 1)
			prov = 0;
		else
			prov = $urandom_range(99, PROVINCE_MAX + 1);
		s = well_formed(prov, $urandom_range(9999));
		if (kind >= 90) begin
			s = {};
			n = $urandom_range(24, 1);
			repeat (n) s.push_back(8'($urandom_range(255)));
		end else if (kind >= 78) begin
			n = $urandom_range(40, 1);
			if (n == 18)
				n = 19;
			while (s.size() > n)
				s.delete(s.size() - 1);
			while (s.size() < n)
				s.push_back($urandom_range(1) ? digit_char($urandom_range(9))
					: 8'($urandom_range(255)));
		end else if (kind >= 66) begin
			s[$urandom_range(16)] = non_digit();
		end else if (kind >= 55) begin
			s[17] = ($urandom_range(3) == 0) ? 8'("x") : 8'($urandom_range(255));
		end
		return s;
	endfunction

	task automatic push_char(input logic [7:0] ch, input logic is_end);
		while (!calm && $urandom_range(99) < 33) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata = ch;
		s_tlast = is_end;
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		chars_sent++;
	endtask

	task automatic send_string(input text_t s);
		foreach (s[i])
			push_char(s[i], i == s.size() - 1);
		strings_sent++;
	endtask

	task automatic set_reference_year(input logic [13:0] year_v);
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_data = year_v;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		years_tried++;
	endtask

	task automatic run_phase();
		int start;
		start = chars_sent;
		while (chars_sent - start < ITEMS_PER_PHASE)
			send_string(random_string());
	endtask

	initial begin
		text_t probe;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		probe = {8'h00};
		send_string(probe);
		probe = {8'hFF};
		send_string(probe);
		send_string(well_formed(PROVINCE_MAX, 9999));
		run_phase();

		set_reference_year(14'h3FFF);
		run_phase();
		calm = 1'b1;
		set_reference_year(14'd0);
		run_phase();
		calm = 1'b0;
		set_reference_year(14'd9999);
		run_phase();
		repeat (3) begin
			set_reference_year(14'($urandom_range(16383)));
			run_phase();
		end

		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d characters in %0d strings under %0d reference years.",
			chars_sent, strings_sent, years_tried);
		$display("Compared %0d results, %0d of them valid numbers; %0d mismatches.",
			results_seen, valid_seen, fails);
		if (fails == 0)
			$display("** id_number_checksum_validator_core: PASSED **");
		else
			$display("** id_number_checksum_validator_core: FAILED **");
		$finish;
	end

endmodule
